// ===== hw/rtl/sil_pkg.sv =====
// Shared types and constants for the sorted insertion list.
package sil_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned INDEX_W   = 5;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned RINDEX_W  = 4;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT       = 3'd0,
    ACT_REMOVE_AT    = 3'd1,
    ACT_REMOVE_FIRST = 3'd2,
    ACT_REMOVE_LAST  = 3'd3,
    ACT_FIND         = 3'd4,
    ACT_READ         = 3'd5,
    ACT_CLEAR        = 3'd6
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/sil_cell.sv =====
// One storage cell of the sorted list: compare, shift in from either neighbor.
module sil_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned POS        = 0
) (
  input  logic                  clk_i,
  input  sil_pkg::cell_cmd_t    cmd_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [CNT_W-1:0]      rem_pos_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  input  logic [DATA_WIDTH-1:0] left_entry_i,
  input  logic [DATA_WIDTH-1:0] right_entry_i,
  input  logic                  left_gt_i,
  input  logic                  left_hit_i,
  output logic [DATA_WIDTH-1:0] entry_o,
  output logic                  gt_o,
  output logic                  hit_o,
  output logic                  first_o
);
  import sil_pkg::*;

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(POS);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic                  occ;
  logic                  eq;

  assign occ     = MY_POS < count_i;
  assign gt_o    = occ && ($signed(key_i) > $signed(entry_q));
  assign eq      = occ && (key_i == entry_q);
  assign first_o = eq && !left_hit_i;
  assign hit_o   = eq || left_hit_i;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (!gt_o) begin
        entry_d = left_gt_i ? key_i : left_entry_i;
      end
    end else if (cmd_i.rem && (MY_POS >= rem_pos_i)) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== hw/rtl/sil_chain.sv =====
// Row of list cells with first-match encode and indexed read.
module sil_chain #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1),
  localparam int unsigned IDX_W     = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  sil_pkg::cell_cmd_t            cmd_i,
  input  logic [CNT_W-1:0]              count_i,
  input  logic [CNT_W-1:0]              rem_pos_i,
  input  logic [DATA_WIDTH-1:0]         key_i,
  input  logic [sil_pkg::INDEX_W-1:0]   rd_idx_i,
  output logic                          hit_o,
  output logic [IDX_W-1:0]              hit_idx_o,
  output logic [DATA_WIDTH-1:0]         rd_data_o
);
  import sil_pkg::*;

  localparam int unsigned SEL_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

  logic [DATA_WIDTH-1:0] entry [DEPTH];
  logic                  gt    [DEPTH];
  logic                  hit   [DEPTH];
  logic                  first [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_entry, right_entry;
    logic                  left_gt, left_hit;

    if (g == 0) begin : g_head
      assign left_entry = '0;
      assign left_gt    = 1'b1;
      assign left_hit   = 1'b0;
    end else begin : g_body
      assign left_entry = entry[g-1];
      assign left_gt    = gt[g-1];
      assign left_hit   = hit[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_entry = entry[g];
    end else begin : g_mid
      assign right_entry = entry[g+1];
    end

    sil_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .POS        (g)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd_i),
      .count_i       (count_i),
      .rem_pos_i     (rem_pos_i),
      .key_i         (key_i),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .left_gt_i     (left_gt),
      .left_hit_i    (left_hit),
      .entry_o       (entry[g]),
      .gt_o          (gt[g]),
      .hit_o         (hit[g]),
      .first_o       (first[g])
    );
  end

  assign hit_o = hit[DEPTH-1];

  always_comb begin
    hit_idx_o = '0;
    rd_data_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        hit_idx_o = hit_idx_o | IDX_W'(i);
      end
      if (SEL_W'(rd_idx_i) == SEL_W'(i)) begin
        rd_data_o = rd_data_o | entry[i];
      end
    end
  end

endmodule

// ===== hw/rtl/sorted_insertion_list_core.sv =====
// Sorted insertion list: ascending store of signed words with insert, remove, find, read, clear.
// Every accepted word returns one result word: a status (ok, empty, bad index, not found,
// full), the read value, the first-match index and the entry count after the action. The list
// lives in a row of DEPTH cells; each cell compares the key against its own entry and takes a
// word from its left or right neighbor, so insert, remove and find touch all entries in the
// same cycle. One word is taken per cycle; the compare plus the first-match ripple through the
// cell row is the longest path. Results sit in an output register, and a new word is taken
// whenever that register is empty or being read in the same cycle. Storage needs no clearing
// after reset; entries past the count are never looked at.
module sorted_insertion_list_core #(
  parameter int unsigned DEPTH      = sil_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = sil_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [sil_pkg::ACTION_W-1:0]  action_i,
  input  logic signed [sil_pkg::VALUE_W-1:0]   value_i,
  input  logic        [sil_pkg::INDEX_W-1:0]   index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [sil_pkg::STATUS_W-1:0]  status_o,
  output logic signed [sil_pkg::VALUE_W-1:0]   result_value_o,
  output logic        [sil_pkg::RINDEX_W-1:0]  result_index_o,
  output logic        [sil_pkg::COUNT_W-1:0]   count_o
);
  import sil_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [VALUE_W-1:0]    rval_q;
  logic [RINDEX_W-1:0]   ridx_q;

  logic                  accept;
  action_e               act;
  status_e               st;
  cell_cmd_t             cmd;
  logic                  ins, rem;
  logic [CNT_W-1:0]      rem_pos;
  logic                  empty, full, idx_bad;
  logic [CMP_W-1:0]      idx_ext;
  logic [63:0]           value_ext;
  logic [DATA_WIDTH-1:0] key;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [63:0]           rd_sext;
  logic [31:0]           hit_ext;
  logic [31:0]           cnt_ext;
  logic [VALUE_W-1:0]    rval;
  logic [RINDEX_W-1:0]   ridx;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign act        = action_e'(action_i);

  assign value_ext = 64'($unsigned(value_i));
  assign key       = value_ext[DATA_WIDTH-1:0];
  assign idx_ext   = CMP_W'(index_i);
  assign empty     = (count_q == '0);
  assign full      = (count_q == CNT_W'(DEPTH));
  assign idx_bad   = idx_ext >= CMP_W'(count_q);
  assign rd_sext   = 64'($signed(rd_data));
  assign hit_ext   = 32'(hit_idx);

  always_comb begin
    st      = ST_OK;
    ins     = 1'b0;
    rem     = 1'b0;
    rem_pos = '0;
    count_d = count_q;
    rval    = '0;
    ridx    = '0;
    unique case (act)
      ACT_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ins     = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      ACT_REMOVE_AT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (idx_bad) begin
          st = ST_BAD_INDEX;
        end else begin
          rem     = 1'b1;
          rem_pos = idx_ext[CNT_W-1:0];
          count_d = count_q - 1'b1;
        end
      end
      ACT_REMOVE_FIRST: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          rem     = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      ACT_REMOVE_LAST: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      ACT_FIND: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (!hit) begin
          st = ST_NOT_FOUND;
        end else begin
          ridx = hit_ext[RINDEX_W-1:0];
        end
      end
      ACT_READ: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (idx_bad) begin
          st = ST_BAD_INDEX;
        end else begin
          rval = rd_sext[VALUE_W-1:0];
        end
      end
      ACT_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign cmd.ins = accept && ins;
  assign cmd.rem = accept && rem;

  sil_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_chain (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .count_i   (count_q),
    .rem_pos_i (rem_pos),
    .key_i     (key),
    .rd_idx_i  (index_i),
    .hit_o     (hit),
    .hit_idx_o (hit_idx),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= st;
      rval_q   <= rval;
      ridx_q   <= ridx;
    end
  end

  assign cnt_ext        = 32'(count_q);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_value_o = rval_q;
  assign result_index_o = ridx_q;
  assign count_o        = cnt_ext[COUNT_W-1:0];

endmodule

// ===== hw/rtl/sil_checker.sv =====
// Port-level checks for the sorted insertion list, bound to the top level.
module sil_checker #(
  parameter int unsigned DEPTH = sil_pkg::DEPTH_DEF
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic        [sil_pkg::ACTION_W-1:0]  action_i,
  input logic signed [sil_pkg::VALUE_W-1:0]   value_i,
  input logic        [sil_pkg::INDEX_W-1:0]   index_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic        [sil_pkg::STATUS_W-1:0]  status_o,
  input logic signed [sil_pkg::VALUE_W-1:0]   result_value_o,
  input logic        [sil_pkg::RINDEX_W-1:0]  result_index_o,
  input logic        [sil_pkg::COUNT_W-1:0]   count_o
);
  import sil_pkg::*;

  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

  logic unused_in;
  assign unused_in = in_valid_i ^ (^action_i) ^ (^value_i) ^ (^index_i);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(result_value_o) && $stable(result_index_o) && $stable(count_o))
    else $error("stalled result word changed");

  a_stall_only_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no pending result");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == FULL_CNT)
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> count_o == '0)
    else $error("empty status with entries stored");

  a_result_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_value_o != '0 || result_index_o != '0) |-> status_o == ST_OK)
    else $error("nonzero result on failed action");

endmodule

bind sorted_insertion_list_core sil_checker #(.DEPTH(DEPTH)) u_sil_checker (.*);
